// File: hw/rtl/orhb_pkg.sv
// Shared constants and types for the overwriting ring history buffer.
package orhb_pkg;

  localparam int DEPTH    = 32;
  localparam int IDX_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SAMPLE_W = 16;
  localparam int COUNT_W  = 6;
  localparam int OP_W     = 2;

  typedef logic [IDX_W-1:0]    idx_t;
  typedef logic [SAMPLE_W-1:0] sample_t;
  typedef logic [COUNT_W-1:0]  count_t;

  typedef enum logic [OP_W-1:0] {
    OP_ADD      = 2'd0,
    OP_READ_ALL = 2'd1,
    OP_READ_NEW = 2'd2,
    OP_NOP      = 2'd3
  } op_t;

  localparam idx_t LAST_IDX = idx_t'(DEPTH - 1);

  // Next slot in the ring, wrapping after the last slot.
  function automatic idx_t ring_next(input idx_t idx);
    ring_next = (idx == LAST_IDX) ? '0 : idx_t'(idx + 1'b1);
  endfunction

  // Number of slots walked from 'from' up to but not including 'to'.
  function automatic idx_t ring_span(input idx_t from, input idx_t to);
    logic [IDX_W:0] span;
    if (to >= from) begin
      span = {1'b0, to} - {1'b0, from};
    end else begin
      span = (IDX_W+1)'(DEPTH) - {1'b0, from} + {1'b0, to};
    end
    ring_span = span[IDX_W-1:0];
  endfunction

endpackage

// File: hw/rtl/orhb_if.sv
// Valid/ready channel interfaces for requests and read results.
interface orhb_req_if;
  import orhb_pkg::*;

  logic            valid;
  logic            ready;
  logic [OP_W-1:0] operation;
  sample_t         sample;

  modport source (output valid, output operation, output sample, input ready);
  modport sink   (input valid, input operation, input sample, output ready);
endinterface

interface orhb_rsp_if;
  import orhb_pkg::*;

  logic    valid;
  logic    ready;
  sample_t value;
  count_t  run_count;
  logic    is_last;
  logic    is_empty;

  modport source (output valid, output value, output run_count, output is_last,
                  output is_empty, input ready);
  modport sink   (input valid, input value, input run_count, input is_last,
                  input is_empty, output ready);
endinterface

// File: hw/rtl/orhb_store.sv
// Sample store: one write port, one read port with registered read data.
module orhb_store (
  input  logic              clk,
  input  logic              wr_en,
  input  orhb_pkg::idx_t    wr_addr,
  input  orhb_pkg::sample_t wr_data,
  input  logic              rd_en,
  input  orhb_pkg::idx_t    rd_addr,
  output orhb_pkg::sample_t rd_data
);
  import orhb_pkg::*;

  sample_t mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, data held while not enabled
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: hw/rtl/overwriting_ring_history_buffer.sv
// Top level of the overwriting ring history buffer.
//
// Usage: requests arrive on 'req' (operation, sample); read results leave on
// 'rsp' (value, run_count, is_last, is_empty). Both are valid/ready channels.
// An add produces nothing; adds sustain one per cycle while no read run is
// being issued. After a read is taken, the block streams its run from the
// store at one result per cycle while the receiver keeps up, and takes no
// request until the last store read of the run has been issued. The first
// result passes from the stream state through the store read port and the
// output register. While the run drains, new adds are already accepted.
// If the receiver stalls, the read data stage and output register hold
// and the stream pauses; nothing is dropped.
// Reset clears the head, tail and read mark, and all valid flags; the
// store contents are left as they are and never read before written.
module overwriting_ring_history_buffer (
  input  logic        clk,
  input  logic        rst,
  orhb_req_if.sink    req,
  orhb_rsp_if.source  rsp
);
  import orhb_pkg::*;

  typedef enum logic {ST_IDLE, ST_STREAM} state_t;

  state_t  state;
  idx_t    head;
  idx_t    tail;
  idx_t    rmark;
  idx_t    pos;
  idx_t    remaining;
  idx_t    run_total;
  logic    run_empty;

  // read data stage
  logic    s1_valid;
  logic    s1_last;
  logic    s1_empty;
  idx_t    s1_count;

  // output register
  logic    out_valid;
  sample_t out_value;
  count_t  out_count;
  logic    out_last;
  logic    out_empty;

  sample_t rd_data;
  logic    accept;
  logic    out_load;
  logic    s1_free;
  logic    issue;
  logic    issue_last;
  logic    wr_en;
  idx_t    start;
  idx_t    span;
  idx_t    tail_next;
  op_t     op;

  assign op        = op_t'(req.operation);
  assign req.ready = (state == ST_IDLE);
  assign accept    = req.valid && req.ready;

  assign out_load   = s1_valid && (!out_valid || rsp.ready);
  assign s1_free    = !s1_valid || out_load;
  assign issue      = (state == ST_STREAM) && s1_free;
  assign issue_last = run_empty || (remaining == idx_t'(1));

  assign wr_en     = accept && (op == OP_ADD);
  assign tail_next = ring_next(tail);
  assign start     = (op == OP_READ_ALL) ? head : rmark;
  assign span      = ring_span(start, tail);

  orhb_store u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (tail),
    .wr_data (req.sample),
    .rd_en   (issue && !run_empty),
    .rd_addr (pos),
    .rd_data (rd_data)
  );

  // ring pointers and stream sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      head  <= '0;
      tail  <= '0;
      rmark <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept) begin
            case (op)
              OP_ADD: begin
                tail <= tail_next;
                if (tail_next == head) begin
                  head <= ring_next(head);
                end
              end
              OP_READ_ALL, OP_READ_NEW: begin
                rmark <= tail;
                state <= ST_STREAM;
              end
              default: ;
            endcase
          end
        end
        ST_STREAM: begin
          if (issue && issue_last) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // run bookkeeping (payload, no reset)
  always_ff @(posedge clk) begin
    if (accept && (op == OP_READ_ALL || op == OP_READ_NEW)) begin
      pos       <= start;
      remaining <= span;
      run_total <= span;
      run_empty <= (span == '0);
    end else if (issue) begin
      pos       <= ring_next(pos);
      remaining <= idx_t'(remaining - 1'b1);
    end
  end

  // read data stage flags
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (issue) begin
      s1_valid <= 1'b1;
    end else if (out_load) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      s1_last  <= issue_last;
      s1_empty <= run_empty;
      s1_count <= run_total;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_value <= s1_empty ? '0 : rd_data;
      out_count <= COUNT_W'(s1_count);
      out_last  <= s1_last;
      out_empty <= s1_empty;
    end
  end

  assign rsp.valid     = out_valid;
  assign rsp.value     = out_value;
  assign rsp.run_count = out_count;
  assign rsp.is_last   = out_last;
  assign rsp.is_empty  = out_empty;

endmodule

// File: tb/sv/overwriting_ring_history_buffer_tb.sv
// Self-checking testbench for the overwriting ring history buffer: queued stimulus, scoreboard.
module overwriting_ring_history_buffer_tb;
  import orhb_pkg::*;

  localparam int WATCHDOG_CYCLES = 2000;
  localparam int SETTLE_CYCLES   = 20;
  localparam int MAX_REPORTS     = 50;

  // Pacing of both channels, carried by each queued request
  typedef enum logic [1:0] {
    PACE_FREE,
    PACE_SLOW_SRC,
    PACE_SLOW_SINK,
    PACE_BOTH
  } pace_t;

  typedef struct {
    op_t     op;
    sample_t smp;
    pace_t   pace;
    bit      wait_drain;
  } request_t;

  typedef struct {
    sample_t value;
    count_t  run_count;
    logic    is_last;
    logic    is_empty;
  } result_t;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    req_valid = 1'b0;
  op_t     req_op = OP_NOP;
  sample_t req_smp = '0;
  logic    rsp_ready = 1'b0;
  pace_t   cur_pace = PACE_FREE;

  request_t request_q[$];
  result_t  pending_results[$];
  int       errors = 0;
  int       idle_cycles = 0;

  // Predicted buffer contents and pointers
  sample_t     hist_mem[DEPTH];
  int unsigned oldest_pos = 0;
  int unsigned next_pos = 0;
  int unsigned seen_pos = 0;

  orhb_req_if req_ch ();
  orhb_rsp_if rsp_ch ();

  assign req_ch.valid     = req_valid;
  assign req_ch.operation = req_op;
  assign req_ch.sample    = req_smp;
  assign rsp_ch.ready     = rsp_ready;

  overwriting_ring_history_buffer dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    if (errors < MAX_REPORTS) begin
      $display("MISMATCH @%0t: %s", $realtime, msg);
    end
    errors++;
  endtask

  function automatic int unsigned src_idle_pct(input pace_t p);
    case (p)
      PACE_SLOW_SRC: return 68;
      PACE_BOTH:     return 7;
      default:       return 0;
    endcase
  endfunction

  function automatic int unsigned sink_stall_pct(input pace_t p);
    case (p)
      PACE_SLOW_SINK: return 68;
      PACE_BOTH:      return 7;
      default:        return 0;
    endcase
  endfunction

  // Expected results of a read run from 'start' up to the newest sample
  function automatic void queue_run(input int unsigned start);
    int unsigned pos;
    int unsigned n;
    result_t     r;
    n = (next_pos + DEPTH - start) % DEPTH;
    if (n == 0) begin
      // empty read: one marker result
      r.value     = '0;
      r.run_count = '0;
      r.is_last   = 1'b1;
      r.is_empty  = 1'b1;
      pending_results.push_back(r);
    end else begin
      pos = start;
      for (int unsigned k = 0; k < n; k++) begin
        r.value     = hist_mem[idx_t'(pos)];
        r.run_count = count_t'(n);
        r.is_last   = (k == n - 1);
        r.is_empty  = 1'b0;
        pending_results.push_back(r);
        pos = (pos + 1) % DEPTH;
      end
    end
    seen_pos = next_pos;
  endfunction

  // Buffer prediction for one accepted request
  function automatic void predict_request(input op_t op, input sample_t smp);
    case (op)
      OP_ADD: begin
        hist_mem[idx_t'(next_pos)] = smp;
        next_pos = (next_pos + 1) % DEPTH;
        // full ring: drop the oldest sample
        if (next_pos == oldest_pos) oldest_pos = (oldest_pos + 1) % DEPTH;
      end
      OP_READ_ALL: queue_run(oldest_pos);
      // read mark is not corrected when adds lap it
      OP_READ_NEW: queue_run(seen_pos);
      default: ;
    endcase
  endfunction

  // Request driver
  always @(posedge clk) begin
    request_t nxt;
    bit       busy;
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      busy = req_valid && !req_ch.ready;
      if (req_valid && req_ch.ready) predict_request(req_op, req_smp);
      if (!busy) begin
        if (request_q.size() != 0 &&
            !(request_q[0].wait_drain && pending_results.size() != 0) &&
            $urandom_range(0, 99) >= src_idle_pct(request_q[0].pace)) begin
          nxt = request_q.pop_front();
          req_valid <= 1'b1;
          req_op    <= nxt.op;
          req_smp   <= nxt.smp;
          cur_pace  <= nxt.pace;
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor and scoreboard
  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      rsp_ready <= 1'b0;
    end else begin
      if (rsp_ch.valid && rsp_ready) begin
        if (pending_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result value=%h", rsp_ch.value));
        end else begin
          want = pending_results.pop_front();
          if (rsp_ch.value !== want.value)
            report_mismatch($sformatf("value %h, want %h", rsp_ch.value, want.value));
          if (rsp_ch.run_count !== want.run_count)
            report_mismatch($sformatf("run_count %0d, want %0d",
                                      rsp_ch.run_count, want.run_count));
          if (rsp_ch.is_last !== want.is_last)
            report_mismatch($sformatf("is_last %b, want %b", rsp_ch.is_last, want.is_last));
          if (rsp_ch.is_empty !== want.is_empty)
            report_mismatch($sformatf("is_empty %b, want %b",
                                      rsp_ch.is_empty, want.is_empty));
        end
      end
      rsp_ready <= ($urandom_range(0, 99) >= sink_stall_pct(cur_pace));
    end
  end

  // Watchdog on cycles without any transaction
  always @(posedge clk) begin
    if ((req_valid && req_ch.ready) || (rsp_ch.valid && rsp_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= WATCHDOG_CYCLES) begin
      report_mismatch("watchdog: no transaction for too long");
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic push_req(input op_t op, input sample_t smp, input pace_t pace,
                          input bit wait_drain = 1'b0);
    request_t r;
    r.op         = op;
    r.smp        = smp;
    r.pace       = pace;
    r.wait_drain = wait_drain;
    request_q.push_back(r);
  endtask

  // Stimulus and end of run
  initial begin
    int    n_items;
    int    burst;
    int    sel;
    pace_t pace;
    pace_t prev_pace;
    bit    first_seq;

    for (int i = 0; i < DEPTH; i++) hist_mem[idx_t'(i)] = '0;

    // Directed: empty reads after reset, unused opcode, extremes, read-new behavior
    push_req(OP_READ_ALL, 16'hFFFF, PACE_FREE);
    push_req(OP_READ_NEW, 16'hFFFF, PACE_FREE);
    push_req(OP_NOP,      16'hFFFF, PACE_FREE);
    push_req(OP_ADD,      16'h0000, PACE_FREE);
    push_req(OP_ADD,      16'hFFFF, PACE_FREE);
    push_req(OP_ADD,      16'hA5A5, PACE_FREE);
    push_req(OP_READ_NEW, 16'h0000, PACE_FREE);
    push_req(OP_READ_NEW, 16'h5A5A, PACE_FREE);
    push_req(OP_ADD,      16'h5A5A, PACE_FREE);
    push_req(OP_READ_ALL, 16'h0000, PACE_FREE);
    push_req(OP_READ_NEW, 16'hFFFF, PACE_FREE);
    push_req(OP_NOP,      16'h0000, PACE_FREE);
    push_req(OP_ADD,      16'h8001, PACE_FREE);
    push_req(OP_READ_ALL, 16'h1234, PACE_FREE, 1'b1);
    n_items = 12;

    // Random: bursts of adds followed by reads; long bursts fill and lap the ring
    first_seq = 1'b1;
    prev_pace = PACE_FREE;
    while (n_items < 400) begin
      pace = pace_t'((n_items / 100) % 4);
      sel  = $urandom_range(0, 9);
      if (first_seq) begin
        burst = 40;                                  // lap the read mark once for sure
      end else if (sel < 6) begin
        burst = $urandom_range(0, 8);
      end else if (sel < 8) begin
        burst = $urandom_range(9, 31);
      end else begin
        burst = $urandom_range(28, 45);
      end
      for (int i = 0; i < burst; i++) begin
        if ($urandom_range(0, 15) == 0)
          push_req(OP_NOP, sample_t'($urandom), pace);
        push_req(OP_ADD, sample_t'($urandom), pace,
                 (i == 0) && (pace != prev_pace));
        n_items++;
      end
      push_req($urandom_range(0, 1) ? OP_READ_NEW : OP_READ_ALL, sample_t'($urandom),
               pace, (burst == 0) && (pace != prev_pace));
      n_items++;
      // back-to-back read: often an empty read-new
      if ($urandom_range(0, 3) == 0) begin
        push_req($urandom_range(0, 2) != 0 ? OP_READ_NEW : OP_READ_ALL,
                 sample_t'($urandom), pace);
        n_items++;
      end
      prev_pace = pace;
      first_seq = 1'b0;
    end

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    while (request_q.size() != 0 || req_valid || pending_results.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// File: sim.f
hw/rtl/orhb_pkg.sv
hw/rtl/orhb_if.sv
hw/rtl/orhb_store.sv
hw/rtl/overwriting_ring_history_buffer.sv
tb/sv/overwriting_ring_history_buffer_tb.sv
